FILE: hdl/tsl_pkg.sv
// shared types and constants for the temperature sensor linearizer
package tsl_pkg;

   localparam int TableEntries = 17;
   localparam int TableIdxW    = $clog2(TableEntries);

   localparam logic [7:0]  HighByteDrop = 8'h14;
   localparam logic [16:0] ScaleBias    = 17'h00050;
   localparam logic [13:0] ScaleRecip   = 14'd13108;
   localparam logic [9:0]  ScaleMax     = 10'd255;

   typedef enum logic {
      MODE_CONVERT = 1'b0,
      MODE_WRITE   = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      CSR_LIMIT_CHECK_OFF = 3'd0,
      CSR_LOW_LIMIT       = 3'd1,
      CSR_HIGH_LIMIT      = 3'd2,
      CSR_FALLBACK_VALUE  = 3'd3,
      CSR_SENSOR_PRESENT  = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [7:0] raw_high;
      logic       below_low;
      logic       above_high;
      logic       used_fallback;
      logic [7:0] weight;
   } ctrl_type;

endpackage

FILE: hdl/tsl_curve_mem.sv
// curve table memory, one write port and two registered read ports
module tsl_curve_mem (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [tsl_pkg::TableIdxW-1:0] wr_addr,
   input  logic [7:0]                    wr_data,
   input  logic                          rd_en,
   input  logic [tsl_pkg::TableIdxW-1:0] rd_addr_a,
   input  logic [tsl_pkg::TableIdxW-1:0] rd_addr_b,
   output logic [7:0]                    rd_data_a_ff,
   output logic [7:0]                    rd_data_b_ff
);

   logic [7:0] curve_mem_ff [tsl_pkg::TableEntries];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         curve_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= curve_mem_ff[rd_addr_a];
         rd_data_b_ff <= curve_mem_ff[rd_addr_b];
      end
   end

endmodule

FILE: hdl/tsl_interp.sv
// interpolation products and high byte adjust, two pipeline stages
module tsl_interp (
   input  logic              clock,
   input  logic              prod_en,
   input  logic              adj_en,
   input  logic [7:0]        curve_lo,
   input  logic [7:0]        curve_hi,
   input  tsl_pkg::ctrl_type ctrl_in,
   input  logic [7:0]        fallback_value,
   output logic [15:0]       adj_ff,
   output tsl_pkg::ctrl_type ctrl_out_ff
);

   logic [7:0]        hi_eff;
   logic [15:0]       prod_hi_in;
   logic [16:0]       prod_lo_wide;
   logic [15:0]       prod_hi_ff;
   logic [15:0]       prod_lo_ff;
   tsl_pkg::ctrl_type ctrl_prod_ff;
   logic [16:0]       sum_wide;
   logic [15:0]       sum;
   logic [15:0]       adj_in;

   // upper entry only matters for a nonzero weight
   assign hi_eff       = (ctrl_in.weight == 8'd0) ? 8'd0 : curve_hi;
   assign prod_hi_in   = hi_eff * ctrl_in.weight;
   assign prod_lo_wide = curve_lo * (9'd256 - {1'b0, ctrl_in.weight});

   always_ff @(posedge clock) begin
      if (prod_en) begin
         prod_hi_ff   <= prod_hi_in;
         prod_lo_ff   <= prod_lo_wide[15:0];
         ctrl_prod_ff <= ctrl_in;
      end
   end

   assign sum_wide = {1'b0, prod_hi_ff} + {1'b0, prod_lo_ff};
   assign sum      = sum_wide[15:0];

   always_comb begin
      if (ctrl_prod_ff.used_fallback) begin
         adj_in = {fallback_value, 8'h00};
      end else if (sum[15:8] < tsl_pkg::HighByteDrop) begin
         adj_in = 16'h0000;
      end else begin
         adj_in = {sum[15:8] - tsl_pkg::HighByteDrop, sum[7:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (adj_en) begin
         adj_ff      <= adj_in;
         ctrl_out_ff <= ctrl_prod_ff;
      end
   end

endmodule

FILE: hdl/tsl_scale.sv
// scaling of the adjusted word to a byte and the result register
module tsl_scale (
   input  logic              clock,
   input  logic              out_en,
   input  logic [15:0]       adj,
   input  tsl_pkg::ctrl_type ctrl_in,
   output logic [7:0]        raw_high_ff,
   output logic              below_low_ff,
   output logic              above_high_ff,
   output logic              used_fallback_ff,
   output logic [15:0]       adjusted_value_ff,
   output logic [7:0]        scaled_temp_ff
);

   logic [16:0] biased;
   logic [11:0] div32;
   logic [25:0] recip_prod;
   logic [9:0]  quot;
   logic [7:0]  scaled_in;

   // divide by 160 as a shift by 5 then multiply by a reciprocal of 5
   assign biased     = {1'b0, adj} + tsl_pkg::ScaleBias;
   assign div32      = biased[16:5];
   assign recip_prod = div32 * tsl_pkg::ScaleRecip;
   assign quot       = recip_prod[25:16];
   assign scaled_in  = (quot > tsl_pkg::ScaleMax) ? 8'hFF : quot[7:0];

   always_ff @(posedge clock) begin
      if (out_en) begin
         raw_high_ff       <= ctrl_in.raw_high;
         below_low_ff      <= ctrl_in.below_low;
         above_high_ff     <= ctrl_in.above_high;
         used_fallback_ff  <= ctrl_in.used_fallback;
         adjusted_value_ff <= adj;
         scaled_temp_ff    <= scaled_in;
      end
   end

endmodule

FILE: hdl/temp_sensor_linearizer_unit.sv
// top level of the temperature sensor linearizer
// A convert beat passes through a chain of registers on its way to the result port: the
// curve memory read register loads at its accept edge, then the product register, the
// adjust register and the result register, from which the result beat is taken. One
// beat is accepted every cycle while the result side keeps up; each stage holds only when
// the one after it is full and stalled, so up to four convert beats are in flight. A table
// write beat with an in-range index updates the curve memory at its accept edge, gives no
// result, and is seen by a convert beat in the next cycle.
module temp_sensor_linearizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [4:0]  req_table_index,
   input  logic [7:0]  req_table_value,
   input  logic [15:0] req_adc_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_raw_high,
   output logic        rsp_below_low,
   output logic        rsp_above_high,
   output logic        rsp_used_fallback,
   output logic [15:0] rsp_adjusted_value,
   output logic [7:0]  rsp_scaled_temp,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic limit_check_off_ff;
   logic [7:0] low_limit_ff;
   logic [7:0] high_limit_ff;
   logic [7:0] fallback_value_ff;
   logic sensor_present_ff;

   logic rd_valid_ff, rd_valid_in;
   logic prod_valid_ff, prod_valid_in;
   logic adj_valid_ff, adj_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rd_en, prod_en, adj_en, out_en;

   logic accept, is_convert, table_wr;
   logic [tsl_pkg::TableIdxW-1:0] seg_addr;
   logic [tsl_pkg::TableIdxW-1:0] seg_next_addr;
   logic [7:0] curve_lo, curve_hi;
   logic [7:0] raw;
   tsl_pkg::ctrl_type ctrl_in;
   tsl_pkg::ctrl_type ctrl_rd_ff;
   tsl_pkg::ctrl_type ctrl_adj;
   logic [15:0] adj;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_check_off_ff <= 1'b0;
         low_limit_ff       <= 8'd0;
         high_limit_ff      <= 8'd255;
         fallback_value_ff  <= 8'd0;
         sensor_present_ff  <= 1'b1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            tsl_pkg::CSR_LIMIT_CHECK_OFF: limit_check_off_ff <= csr_wdata[0];
            tsl_pkg::CSR_LOW_LIMIT:       low_limit_ff       <= csr_wdata;
            tsl_pkg::CSR_HIGH_LIMIT:      high_limit_ff      <= csr_wdata;
            tsl_pkg::CSR_FALLBACK_VALUE:  fallback_value_ff  <= csr_wdata;
            tsl_pkg::CSR_SENSOR_PRESENT:  sensor_present_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // stage enables, a stage moves when empty or when the next one moves
   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign adj_en    = !adj_valid_ff || out_en;
   assign prod_en   = !prod_valid_ff || adj_en;
   assign rd_en     = !rd_valid_ff || prod_en;
   assign req_ready = rd_en;

   assign accept     = req_valid && req_ready;
   assign is_convert = accept && (req_mode == tsl_pkg::MODE_CONVERT);
   assign table_wr   = accept && (req_mode == tsl_pkg::MODE_WRITE)
                       && (req_table_index < 5'(tsl_pkg::TableEntries));

   assign seg_addr      = {1'b0, req_adc_sample[15:12]};
   assign seg_next_addr = seg_addr + 5'd1;
   assign raw           = req_adc_sample[15:8];

   always_comb begin
      ctrl_in.raw_high      = raw;
      ctrl_in.weight        = req_adc_sample[11:4];
      ctrl_in.below_low     = 1'b0;
      ctrl_in.above_high    = 1'b0;
      ctrl_in.used_fallback = 1'b0;
      if (!sensor_present_ff) begin
         ctrl_in.used_fallback = 1'b1;
      end else if (!limit_check_off_ff) begin
         if (raw < low_limit_ff) begin
            ctrl_in.below_low = 1'b1;
         end else if (raw > high_limit_ff) begin
            ctrl_in.above_high = 1'b1;
         end
         ctrl_in.used_fallback = ctrl_in.below_low || ctrl_in.above_high;
      end
   end

   always_comb begin
      rd_valid_in   = rd_en ? is_convert : rd_valid_ff;
      prod_valid_in = prod_en ? rd_valid_ff : prod_valid_ff;
      adj_valid_in  = adj_en ? prod_valid_ff : adj_valid_ff;
      rsp_valid_in  = out_en ? adj_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         adj_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff   <= rd_valid_in;
         prod_valid_ff <= prod_valid_in;
         adj_valid_ff  <= adj_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         ctrl_rd_ff <= ctrl_in;
      end
   end

   tsl_curve_mem u_curve_mem (
      .clock        (clock),
      .wr_en        (table_wr),
      .wr_addr      (req_table_index),
      .wr_data      (req_table_value),
      .rd_en        (rd_en),
      .rd_addr_a    (seg_addr),
      .rd_addr_b    (seg_next_addr),
      .rd_data_a_ff (curve_lo),
      .rd_data_b_ff (curve_hi)
   );

   tsl_interp u_interp (
      .clock          (clock),
      .prod_en        (prod_en),
      .adj_en         (adj_en),
      .curve_lo       (curve_lo),
      .curve_hi       (curve_hi),
      .ctrl_in        (ctrl_rd_ff),
      .fallback_value (fallback_value_ff),
      .adj_ff         (adj),
      .ctrl_out_ff    (ctrl_adj)
   );

   tsl_scale u_scale (
      .clock             (clock),
      .out_en            (out_en),
      .adj               (adj),
      .ctrl_in           (ctrl_adj),
      .raw_high_ff       (rsp_raw_high),
      .below_low_ff      (rsp_below_low),
      .above_high_ff     (rsp_above_high),
      .used_fallback_ff  (rsp_used_fallback),
      .adjusted_value_ff (rsp_adjusted_value),
      .scaled_temp_ff    (rsp_scaled_temp)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/tsl_checker.sv
// port level checks for the linearizer, bound to the top level
module tsl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_raw_high,
   input logic        rsp_below_low,
   input logic        rsp_above_high,
   input logic        rsp_used_fallback,
   input logic [15:0] rsp_adjusted_value,
   input logic [7:0]  rsp_scaled_temp
);

   // stalled result beat stays valid and holds its adjusted value, raw high byte and scaled temperature
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_adjusted_value)
         && $stable(rsp_raw_high) && $stable(rsp_scaled_temp))
      else $error("result beat changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_below_low && rsp_above_high))
      else $error("both limit flags set");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_below_low || rsp_above_high) |-> rsp_used_fallback)
      else $error("limit violation without fallback");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_used_fallback |-> rsp_adjusted_value[7:0] == 8'h00)
      else $error("fallback word has nonzero low byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_adjusted_value >= 16'd40720 |-> rsp_scaled_temp == 8'hFF)
      else $error("scaled value not saturated");

endmodule

bind temp_sensor_linearizer_unit tsl_checker u_tsl_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_raw_high       (rsp_raw_high),
   .rsp_below_low      (rsp_below_low),
   .rsp_above_high     (rsp_above_high),
   .rsp_used_fallback  (rsp_used_fallback),
   .rsp_adjusted_value (rsp_adjusted_value),
   .rsp_scaled_temp    (rsp_scaled_temp)
);
